>>> rtl/mpwa_pkg.sv
package mpwa_pkg;

   localparam int VALUE_BITS   = 16;
   localparam int MAX_CHANNELS_DEF = 16;
   localparam int MAX_ROWS_DEF     = 32;
   localparam int MAX_COLS_DEF     = 32;
   localparam int MAX_WINDOW_DEF   = 8;

   // signed working width for window coordinates (row - padding + offset)
   localparam int COORD_BITS = 9;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 6;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_WIN_SIDE      = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PADDING       = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROWS_USED     = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COLS_USED     = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CHANNELS_USED = 3'd4;

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

   typedef struct packed {
      logic                         kind;
      logic [3:0]                   channel;
      logic [5:0]                   row;
      logic [5:0]                   col;
      logic signed [VALUE_BITS-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] max_value;
      logic [4:0]                   max_row;
      logic [4:0]                   max_col;
      logic                         status;
   } rsp_type;

   typedef struct packed {
      logic write;   // store the element on the request word
      logic start;   // latch a query and clear the running maximum
      logic scan;    // read one window cell and advance the offsets
      logic load;    // move the result into the output register
   } cmd_type;

   typedef struct packed {
      logic query_bad;  // query on the request word lies outside the output or the used channels
      logic last;       // offsets sit on the final window cell
   } stat_type;

endpackage

>>> rtl/max_pool_window_argmax.sv
// Stride-1 max pooling with argmax over a stored multi-channel feature map of
// signed Q8.8 words. A write word (kind 0) stores one element and gives no
// result; writes outside the used map are dropped. A query word (kind 1)
// scans the N x N window (N the window side register) at
// (row - padding, col - padding), one cell per cycle through the single read
// port of the map memory, skipping cells off the map, and returns the maximum
// with the row and column of its first occurrence. The scan is followed by a
// drain state and a result stage that waits for the result register; a query
// outside the output size skips the scan and returns status 1.
// req_stall is high while a query is in progress. Never-written map entries
// read back as undefined data. Registers may be written only while idle.
module max_pool_window_argmax #(
   parameter int MAX_CHANNELS = mpwa_pkg::MAX_CHANNELS_DEF,
   parameter int MAX_ROWS     = mpwa_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS     = mpwa_pkg::MAX_COLS_DEF,
   parameter int MAX_WINDOW   = mpwa_pkg::MAX_WINDOW_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  mpwa_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output mpwa_pkg::rsp_type                   rsp_data,
   input  logic                                csr_write,
   input  logic [mpwa_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [mpwa_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import mpwa_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   mpwa_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_data.kind),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   mpwa_datapath #(
      .MAX_CHANNELS (MAX_CHANNELS),
      .MAX_ROWS     (MAX_ROWS),
      .MAX_COLS     (MAX_COLS),
      .MAX_WINDOW   (MAX_WINDOW)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_data  (rsp_data)
   );

endmodule

>>> rtl/mpwa_datapath.sv
module mpwa_datapath #(
   parameter int MAX_CHANNELS = mpwa_pkg::MAX_CHANNELS_DEF,
   parameter int MAX_ROWS     = mpwa_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS     = mpwa_pkg::MAX_COLS_DEF,
   parameter int MAX_WINDOW   = mpwa_pkg::MAX_WINDOW_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write,
   input  logic [mpwa_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [mpwa_pkg::CSR_DATA_BITS-1:0]    csr_data,
   input  mpwa_pkg::req_type                     req_data,
   input  mpwa_pkg::cmd_type                     cmd,
   output mpwa_pkg::stat_type                    stat,
   output mpwa_pkg::rsp_type                     rsp_data
);
   import mpwa_pkg::*;

   localparam int DEPTH = MAX_CHANNELS * MAX_ROWS * MAX_COLS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int WW    = $clog2(MAX_WINDOW + 1);
   localparam int CB    = COORD_BITS;

   // configuration registers
   logic [3:0] win_ff;
   logic [2:0] pad_ff;
   logic [5:0] rows_ff;
   logic [5:0] cols_ff;
   logic [4:0] chans_ff;

   // effective (saturated) geometry
   logic [WW-1:0] ws_eff;
   logic [2:0]    pad_eff;
   logic [5:0]    nr;
   logic [5:0]    nc;
   logic [4:0]    nch;
   logic signed [CB-1:0] nr_s;
   logic signed [CB-1:0] nc_s;
   logic signed [CB-1:0] out_rows;
   logic signed [CB-1:0] out_cols;
   logic signed [CB-1:0] row_s;
   logic signed [CB-1:0] col_s;

   // query state
   logic [3:0]           ch_ff;
   logic signed [CB-1:0] r0_ff;
   logic signed [CB-1:0] c0_ff;
   logic                 bad_ff;
   logic [WW-1:0]        dy_ff;
   logic [WW-1:0]        dz_ff;
   logic [WW-1:0]        dy_in;
   logic [WW-1:0]        dz_in;
   logic signed [CB-1:0] y;
   logic signed [CB-1:0] z;
   logic                 in_map;
   logic                 wr_in_map;

   // memory and compare stage
   logic [VALUE_BITS-1:0] mem [DEPTH];
   logic [AW-1:0]         wr_addr;
   logic [AW-1:0]         rd_addr;
   logic signed [VALUE_BITS-1:0] rd_data_ff;
   logic                  hit_ff;
   logic                  hit_in;
   logic signed [CB-1:0]  y_d_ff;
   logic signed [CB-1:0]  z_d_ff;
   logic signed [VALUE_BITS-1:0] best_ff;
   logic [4:0]            best_r_ff;
   logic [4:0]            best_c_ff;
   rsp_type               rsp_ff;

   always_comb begin
      if (win_ff == 4'd0) begin
         ws_eff = WW'(1);
      end else if (32'(win_ff) > MAX_WINDOW) begin
         ws_eff = WW'(MAX_WINDOW);
      end else begin
         ws_eff = WW'(win_ff);
      end
      if (32'(pad_ff) < 32'(ws_eff)) begin
         pad_eff = pad_ff;
      end else begin
         pad_eff = 3'(ws_eff - WW'(1));
      end
      if (rows_ff == 6'd0) begin
         nr = 6'd1;
      end else if (32'(rows_ff) > MAX_ROWS) begin
         nr = 6'(MAX_ROWS);
      end else begin
         nr = rows_ff;
      end
      if (cols_ff == 6'd0) begin
         nc = 6'd1;
      end else if (32'(cols_ff) > MAX_COLS) begin
         nc = 6'(MAX_COLS);
      end else begin
         nc = cols_ff;
      end
      if (chans_ff == 5'd0) begin
         nch = 5'd1;
      end else if (32'(chans_ff) > MAX_CHANNELS) begin
         nch = 5'(MAX_CHANNELS);
      end else begin
         nch = chans_ff;
      end
   end

   assign nr_s     = CB'(nr);
   assign nc_s     = CB'(nc);
   assign row_s    = CB'(req_data.row);
   assign col_s    = CB'(req_data.col);
   // output size may go to zero or below; signed compare then flags every query
   assign out_rows = nr_s + CB'({pad_eff, 1'b0}) - CB'(ws_eff) + CB'(1);
   assign out_cols = nc_s + CB'({pad_eff, 1'b0}) - CB'(ws_eff) + CB'(1);

   assign stat.query_bad = ({1'b0, req_data.channel} >= nch) ||
                           (row_s >= out_rows) || (col_s >= out_cols);
   assign stat.last      = (dy_ff == ws_eff - WW'(1)) && (dz_ff == ws_eff - WW'(1));

   assign wr_in_map = ({1'b0, req_data.channel} < nch) &&
                      (req_data.row < nr) && (req_data.col < nc);

   assign y      = r0_ff + CB'(dy_ff);
   assign z      = c0_ff + CB'(dz_ff);
   assign in_map = (y >= 0) && (z >= 0) && (y < nr_s) && (z < nc_s);
   assign hit_in = cmd.scan && in_map;

   assign wr_addr = AW'((32'(req_data.channel) * MAX_ROWS + 32'(req_data.row)) * MAX_COLS
                        + 32'(req_data.col));
   assign rd_addr = AW'((32'(ch_ff) * MAX_ROWS + 32'(y)) * MAX_COLS + 32'(z));

   always_comb begin
      dy_in = dy_ff;
      dz_in = dz_ff;
      if (cmd.start) begin
         dy_in = '0;
         dz_in = '0;
      end else if (cmd.scan) begin
         if (dz_ff == ws_eff - WW'(1)) begin
            dz_in = '0;
            dy_in = dy_ff + WW'(1);
         end else begin
            dz_in = dz_ff + WW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff   <= 4'd2;
         pad_ff   <= 3'd0;
         rows_ff  <= 6'd32;
         cols_ff  <= 6'd32;
         chans_ff <= 5'd16;
         hit_ff   <= 1'b0;
      end else begin
         hit_ff <= hit_in;
         if (csr_write) begin
            case (csr_index)
               CSR_WIN_SIDE:      win_ff   <= csr_data[3:0];
               CSR_PADDING:       pad_ff   <= csr_data[2:0];
               CSR_ROWS_USED:     rows_ff  <= csr_data[5:0];
               CSR_COLS_USED:     cols_ff  <= csr_data[5:0];
               CSR_CHANNELS_USED: chans_ff <= csr_data[4:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write && wr_in_map) begin
         mem[wr_addr] <= req_data.value;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      dy_ff  <= dy_in;
      dz_ff  <= dz_in;
      y_d_ff <= y;
      z_d_ff <= z;
      if (cmd.start) begin
         ch_ff     <= req_data.channel;
         r0_ff     <= row_s - CB'(pad_eff);
         c0_ff     <= col_s - CB'(pad_eff);
         bad_ff    <= stat.query_bad;
         best_ff   <= {1'b1, {(VALUE_BITS-1){1'b0}}};
         best_r_ff <= 5'd0;
         best_c_ff <= 5'd0;
      end else if (hit_ff && (rd_data_ff > best_ff)) begin
         // strictly greater keeps the first maximum in scan order
         best_ff   <= rd_data_ff;
         best_r_ff <= y_d_ff[4:0];
         best_c_ff <= z_d_ff[4:0];
      end
      if (cmd.load) begin
         if (bad_ff) begin
            rsp_ff.max_value <= '0;
            rsp_ff.max_row   <= 5'd0;
            rsp_ff.max_col   <= 5'd0;
            rsp_ff.status    <= STATUS_RANGE;
         end else begin
            rsp_ff.max_value <= best_ff;
            rsp_ff.max_row   <= best_r_ff;
            rsp_ff.max_col   <= best_c_ff;
            rsp_ff.status    <= STATUS_OK;
         end
      end
   end

   assign rsp_data = rsp_ff;

endmodule

>>> rtl/mpwa_control.sv
module mpwa_control (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_kind,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  mpwa_pkg::stat_type   stat,
   output mpwa_pkg::cmd_type    cmd
);
   import mpwa_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      idle;

   assign idle      = (state_ff == ST_IDLE);
   assign req_stall = !idle;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.write = idle && req_valid && (req_kind == KIND_WRITE);
      cmd.start = idle && req_valid && (req_kind == KIND_QUERY);
      cmd.scan  = (state_ff == ST_SCAN);
      // the result register frees up as the waiting word is taken
      cmd.load  = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.start) begin
               state_in = stat.query_bad ? ST_DONE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (stat.last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_DONE;
         ST_DONE: begin
            if (cmd.load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.write, cmd.start, cmd.scan, cmd.load}))
      else $error("more than one datapath command at once");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (rsp_valid && state_ff == ST_IDLE))
      else $error("loaded result not presented");

   a_scan_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && !stat.last) |=> (state_ff == ST_SCAN))
      else $error("window scan left early");

   a_drain_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |=> (state_ff == ST_DONE && !req_stall == 1'b0))
      else $error("drain not followed by result stage");
`endif

endmodule
